FILE: hdl/clf_pkg.sv
// ---------------------------------------------------------------------------
// clf_pkg
// Shared types and constants of the character-LCD write formatter.
// ---------------------------------------------------------------------------
package clf_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF   = 10;
    localparam int LINE_COLUMNS_DEF = 16;

    localparam int NUMBER_FIELD_W   = 32;
    localparam int CFG_INDEX_W      = 2;

    localparam logic [7:0] ROW0_BASE  = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'hC0;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [7:0] WRAP_INDEX_RST    = 8'd15;
    localparam logic [7:0] LINE2_COMMAND_RST = 8'hC0;
    localparam logic [7:0] CLEAR_COMMAND_RST = 8'h01;

    localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_INDEX    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE2_COMMAND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_COMMAND = 2'd2;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    typedef enum logic [2:0] {
        ACT_COMMAND   = 3'd0,
        ACT_CHAR      = 3'd1,
        ACT_STR_CHAR  = 3'd2,
        ACT_NUMBER    = 3'd3,
        ACT_CURSOR    = 3'd4,
        ACT_CLEAR     = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAR,
        S_CONV,
        S_SKIP,
        S_DIGIT
    } t_state;

    // status of the decimal converter seen by the sequencer
    typedef struct packed {
        logic       busy;
        logic       overflow;
        logic [3:0] digit;
    } t_bcd_status;

endpackage

FILE: hdl/clf_bin2bcd.sv
// ---------------------------------------------------------------------------
// clf_bin2bcd
// Bit-serial binary to decimal converter (shift and add three), followed by
// a digit shifter that presents the most significant digit first.
// ---------------------------------------------------------------------------
module clf_bin2bcd #(
    parameter int NUMBER_WIDTH = clf_pkg::NUMBER_WIDTH_DEF,
    parameter int MAX_DIGITS   = clf_pkg::MAX_DIGITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUMBER_WIDTH-1:0] i_value,
    input  logic                    i_shift,
    output clf_pkg::t_bcd_status    o_status
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);

    logic [NUMBER_WIDTH-1:0] r_bin;
    logic [BCD_W-1:0]        r_bcd;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_ovf;
    logic [BCD_W-1:0]        adj;

    // add three to every digit of five or more before doubling
    always_comb begin
        adj = r_bcd;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUMBER_WIDTH);
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            // carry out of the top digit means the value has outgrown the digit count
            r_ovf  <= r_ovf | adj[BCD_W-1];
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= r_bin << 1;
            r_bcd <= {adj[BCD_W-2:0], r_bin[NUMBER_WIDTH-1]};
        end else if (i_shift) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'b0000};
        end
    end

    assign o_status.busy     = r_busy;
    assign o_status.overflow = r_ovf;
    assign o_status.digit    = r_bcd[BCD_W-1 -: 4];

endmodule

FILE: hdl/char_lcd_write_formatter_core.sv
// ---------------------------------------------------------------------------
// char_lcd_write_formatter_core: display requests to character-LCD writes.
// A one-write request shows its word on the master side in the cycle after accept;
// a number is converted bit by bit, then leading zeros are skipped and one digit a cycle
// is loaded, most significant first, whenever the output register is free.
// Next item is taken once the last word is loaded and the output register is free.
// Reset (synchronous, active low) restores the config registers and position 0.
// ---------------------------------------------------------------------------
module char_lcd_write_formatter_core #(
    parameter int NUMBER_WIDTH = clf_pkg::NUMBER_WIDTH_DEF,
    parameter int MAX_DIGITS   = clf_pkg::MAX_DIGITS_DEF,
    parameter int LINE_COLUMNS = clf_pkg::LINE_COLUMNS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [clf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [7:0]                        i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // byte_value[7:0], number_value[39:8], cursor_row[47:40], cursor_col[55:48]
    input  logic [55:0]                       s_axis_tdata,
    // action[2:0], string_start[3]
    input  logic [3:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // bus_byte[7:0]
    output logic [7:0]                        m_axis_tdata,
    // reg_select[0]
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int DIG_W = $clog2(MAX_DIGITS + 1);

    logic [7:0]  r_wrap_index, r_line2_cmd, r_clear_cmd;
    logic [7:0]  r_str_pos, n_str_pos;
    logic [7:0]  r_char, n_char;
    logic [DIG_W-1:0] r_dig_left, n_dig_left;
    clf_pkg::t_state r_state, n_state;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_rs, n_out_rs;
    logic        r_out_last, n_out_last;

    logic        out_free;
    logic        in_accept;
    logic        bcd_start;
    logic        bcd_shift;
    logic [NUMBER_WIDTH-1:0] num_value;
    clf_pkg::t_bcd_status bcd;

    clf_pkg::t_action in_action;
    logic [7:0]  in_byte, in_row, in_col;
    logic        in_start;
    logic [7:0]  pos_eff, cur_addr;

    assign in_action = clf_pkg::t_action'(s_axis_tuser[2:0]);
    assign in_start  = s_axis_tuser[3];
    assign in_byte   = s_axis_tdata[7:0];
    assign in_row    = s_axis_tdata[47:40];
    assign in_col    = s_axis_tdata[55:48];

    generate
        if (NUMBER_WIDTH <= clf_pkg::NUMBER_FIELD_W) begin : g_num_narrow
            assign num_value = s_axis_tdata[8 +: NUMBER_WIDTH];
        end else begin : g_num_wide
            assign num_value = {{(NUMBER_WIDTH - clf_pkg::NUMBER_FIELD_W){1'b0}},
                                s_axis_tdata[39:8]};
        end
    endgenerate

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == clf_pkg::S_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pos_eff       = in_start ? 8'd0 : r_str_pos;

    always_comb begin
        if (in_row == 8'd0) begin
            cur_addr = clf_pkg::ROW0_BASE;
        end else if (in_row == 8'd1) begin
            cur_addr = clf_pkg::ROW1_BASE;
        end else begin
            cur_addr = 8'd0;
        end
        if (in_col < 8'(LINE_COLUMNS)) begin
            cur_addr = cur_addr + in_col;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_index <= clf_pkg::WRAP_INDEX_RST;
            r_line2_cmd  <= clf_pkg::LINE2_COMMAND_RST;
            r_clear_cmd  <= clf_pkg::CLEAR_COMMAND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                clf_pkg::CFG_WRAP_INDEX:    r_wrap_index <= i_cfg_data;
                clf_pkg::CFG_LINE2_COMMAND: r_line2_cmd  <= i_cfg_data;
                clf_pkg::CFG_CLEAR_COMMAND: r_clear_cmd  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_str_pos   = r_str_pos;
        n_char      = r_char;
        n_dig_left  = r_dig_left;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_rs    = r_out_rs;
        n_out_last  = r_out_last;
        bcd_start   = 1'b0;
        bcd_shift   = 1'b0;

        unique case (r_state)
            clf_pkg::S_IDLE: begin
                if (in_accept) begin
                    unique case (in_action)
                        clf_pkg::ACT_COMMAND, clf_pkg::ACT_CHAR: begin
                            n_out_valid = 1'b1;
                            n_out_byte  = in_byte;
                            n_out_rs    = (in_action == clf_pkg::ACT_CHAR);
                            n_out_last  = 1'b1;
                        end
                        clf_pkg::ACT_STR_CHAR: begin
                            n_str_pos   = pos_eff + 8'd1;
                            n_out_valid = 1'b1;
                            if (pos_eff == r_wrap_index) begin
                                // line-two command first, hold the character
                                n_out_byte = r_line2_cmd;
                                n_out_rs   = clf_pkg::RS_COMMAND;
                                n_out_last = 1'b0;
                                n_char     = in_byte;
                                n_state    = clf_pkg::S_CHAR;
                            end else begin
                                n_out_byte = in_byte;
                                n_out_rs   = clf_pkg::RS_DATA;
                                n_out_last = 1'b1;
                            end
                        end
                        clf_pkg::ACT_NUMBER: begin
                            bcd_start  = 1'b1;
                            n_dig_left = DIG_W'(MAX_DIGITS);
                            n_state    = clf_pkg::S_CONV;
                        end
                        clf_pkg::ACT_CURSOR: begin
                            n_out_valid = 1'b1;
                            n_out_byte  = cur_addr;
                            n_out_rs    = clf_pkg::RS_COMMAND;
                            n_out_last  = 1'b1;
                        end
                        clf_pkg::ACT_CLEAR: begin
                            n_out_valid = 1'b1;
                            n_out_byte  = r_clear_cmd;
                            n_out_rs    = clf_pkg::RS_COMMAND;
                            n_out_last  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            clf_pkg::S_CHAR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_char;
                    n_out_rs    = clf_pkg::RS_DATA;
                    n_out_last  = 1'b1;
                    n_state     = clf_pkg::S_IDLE;
                end
            end
            clf_pkg::S_CONV: begin
                if (!bcd.busy) begin
                    n_state = clf_pkg::S_SKIP;
                end
            end
            clf_pkg::S_SKIP: begin
                // drop leading zeros, keeping the last digit, unless the value overflowed the digit count
                if (!bcd.overflow && bcd.digit == 4'd0 && r_dig_left > DIG_W'(1)) begin
                    bcd_shift  = 1'b1;
                    n_dig_left = r_dig_left - DIG_W'(1);
                end else begin
                    n_state = clf_pkg::S_DIGIT;
                end
            end
            clf_pkg::S_DIGIT: begin
                if (out_free) begin
                    bcd_shift   = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = clf_pkg::ASCII_ZERO + {4'b0000, bcd.digit};
                    n_out_rs    = clf_pkg::RS_DATA;
                    n_out_last  = (r_dig_left == DIG_W'(1));
                    n_dig_left  = r_dig_left - DIG_W'(1);
                    if (r_dig_left == DIG_W'(1)) begin
                        n_state = clf_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = clf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clf_pkg::S_IDLE;
            r_str_pos   <= 8'd0;
            r_dig_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_str_pos   <= n_str_pos;
            r_dig_left  <= n_dig_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_out_byte <= n_out_byte;
        r_out_rs   <= n_out_rs;
        r_out_last <= n_out_last;
    end

    clf_bin2bcd #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .MAX_DIGITS   (MAX_DIGITS)
    ) u_bin2bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (bcd_start),
        .i_value  (num_value),
        .i_shift  (bcd_shift),
        .o_status (bcd)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_rs;
    assign m_axis_tlast  = r_out_last;

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == clf_pkg::S_IDLE)
        else $error("input taken outside idle");

    a_number_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_action == clf_pkg::ACT_NUMBER) |=> bcd.busy)
        else $error("converter did not start");

    a_digits_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clf_pkg::S_SKIP || r_state == clf_pkg::S_DIGIT) |-> r_dig_left != '0)
        else $error("digit count ran out");

    a_open_item_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_state != clf_pkg::S_IDLE)
        else $error("non-final word while idle");

endmodule

FILE: dv/tb_char_lcd_write_formatter_core.sv
// ---------------------------------------------------------------------------
// tb_char_lcd_write_formatter_core
// Self-checking bench for the character-LCD write formatter. Display requests
// go in on the slave stream and each one is predicted into the LCD bus writes
// it must produce. Every write on the master stream is checked in order. Both
// streams idle at random, and the run moves through several register settings,
// the extremes among them.
// ---------------------------------------------------------------------------
module tb_char_lcd_write_formatter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // worst number: full conversion, leading-zero skip, then every digit
    localparam int DRAIN_CYCLES = clf_pkg::NUMBER_WIDTH_DEF + 2 * clf_pkg::MAX_DIGITS_DEF + 40;

    // action codes the block ignores
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    typedef struct packed {
        logic       rs;
        logic [7:0] bus_byte;
        logic       last;
    } t_lcd_write;

    typedef struct packed {
        logic [2:0]  act;
        logic        start;
        logic [7:0]  bval;
        logic [31:0] num;
        logic [7:0]  row;
        logic [7:0]  col;
    } t_lcd_request;

    class t_lcd_write_scoreboard;
        logic [7:0]  wrap_index;
        logic [7:0]  line2_cmd;
        logic [7:0]  clear_cmd;
        logic [7:0]  str_pos;
        t_lcd_write  pending_writes[$];
        int unsigned errors;

        function new();
            wrap_index = clf_pkg::WRAP_INDEX_RST;
            line2_cmd  = clf_pkg::LINE2_COMMAND_RST;
            clear_cmd  = clf_pkg::CLEAR_COMMAND_RST;
            str_pos    = 8'd0;
            errors     = 0;
        endfunction

        function void set_reg(logic [clf_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
            case (idx)
                clf_pkg::CFG_WRAP_INDEX:    wrap_index = val;
                clf_pkg::CFG_LINE2_COMMAND: line2_cmd  = val;
                clf_pkg::CFG_CLEAR_COMMAND: clear_cmd  = val;
                default: ;
            endcase
        endfunction

        function void push_write(logic rs, logic [7:0] b, logic last);
            pending_writes.push_back({rs, b, last});
        endfunction

        // predict the writes of one accepted request
        function void take_request(logic [3:0] user, logic [55:0] data);
            logic [2:0]  act;
            logic        start;
            logic [7:0]  bval;
            logic [31:0] num;
            logic [7:0]  row;
            logic [7:0]  col;
            logic [7:0]  addr;
            logic [3:0]  digit[clf_pkg::MAX_DIGITS_DEF];
            int          n;
            act   = user[2:0];
            start = user[3];
            bval  = data[7:0];
            num   = data[39:8];
            row   = data[47:40];
            col   = data[55:48];
            case (act)
                clf_pkg::ACT_COMMAND: push_write(clf_pkg::RS_COMMAND, bval, 1'b1);
                clf_pkg::ACT_CHAR:    push_write(clf_pkg::RS_DATA, bval, 1'b1);
                clf_pkg::ACT_STR_CHAR: begin
                    if (start) str_pos = 8'd0;
                    if (str_pos == wrap_index)
                        push_write(clf_pkg::RS_COMMAND, line2_cmd, 1'b0);
                    push_write(clf_pkg::RS_DATA, bval, 1'b1);
                    str_pos = str_pos + 8'd1;
                end
                clf_pkg::ACT_NUMBER: begin
                    n = 0;
                    do begin
                        digit[n] = 4'(num % 10);
                        num = num / 10;
                        n++;
                    end while (num != 0 && n < clf_pkg::MAX_DIGITS_DEF);
                    // most significant digit first
                    for (int k = n - 1; k >= 0; k--)
                        push_write(clf_pkg::RS_DATA, clf_pkg::ASCII_ZERO + {4'd0, digit[k]},
                                   k == 0);
                end
                clf_pkg::ACT_CURSOR: begin
                    if (row == 8'd0)      addr = clf_pkg::ROW0_BASE;
                    else if (row == 8'd1) addr = clf_pkg::ROW1_BASE;
                    else                  addr = 8'h00;
                    if (col < clf_pkg::LINE_COLUMNS_DEF) addr = addr + col;
                    push_write(clf_pkg::RS_COMMAND, addr, 1'b1);
                end
                clf_pkg::ACT_CLEAR: push_write(clf_pkg::RS_COMMAND, clear_cmd, 1'b1);
                default: ;
            endcase
        endfunction

        function void check_write(logic rs, logic [7:0] b, logic last);
            t_lcd_write w;
            if (pending_writes.size() == 0) begin
                $error("unexpected write: reg_select=%0d bus_byte=0x%02h last=%0d", rs, b, last);
                errors++;
                return;
            end
            w = pending_writes.pop_front();
            if (rs !== w.rs) begin
                $error("reg_select: expected %0d, got %0d", w.rs, rs);
                errors++;
            end
            if (b !== w.bus_byte) begin
                $error("bus_byte: expected 0x%02h, got 0x%02h", w.bus_byte, b);
                errors++;
            end
            if (last !== w.last) begin
                $error("last: expected %0d, got %0d", w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [clf_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [7:0]                      i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [55:0]                     s_axis_tdata;
    logic [3:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [7:0]                      m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;

    t_lcd_write_scoreboard sb = new();
    int unsigned cycle_count = 0;
    bit tx_throttle = 1'b1;
    bit rx_throttle = 1'b1;
    int rx_stall_left = 0;

    char_lcd_write_formatter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[char_lcd_write_formatter_core] ERROR");
            $finish;
        end
    end

    // note requests before checking writes that land on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_write(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output back-pressure
    always @(negedge i_clk) begin
        if (!rx_throttle) begin
            m_axis_tready = 1'b1;
        end else if (rx_stall_left > 0) begin
            m_axis_tready = 1'b0;
            rx_stall_left--;
        end else begin
            rx_stall_left = pick_gap();
            m_axis_tready = (rx_stall_left == 0);
            if (rx_stall_left > 0) rx_stall_left--;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom());
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom());
    endfunction

    function automatic logic [31:0] rand_number();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom_range(1, 9);
            2: return $urandom_range(10, 99999);
            3: return $urandom_range(32'd1_000_000_000, 32'hFFFF_FFFF);
            4: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_lcd_request rand_request();
        t_lcd_request r;
        int pick;
        pick    = $urandom_range(0, 99);
        r.bval  = rand_byte();
        r.num   = rand_number();
        r.row   = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : rand_byte();
        r.col   = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : rand_byte();
        r.start = ($urandom_range(0, 7) == 0);
        if (pick < 15)      r.act = clf_pkg::ACT_COMMAND;
        else if (pick < 30) r.act = clf_pkg::ACT_CHAR;
        else if (pick < 45) r.act = clf_pkg::ACT_STR_CHAR;
        else if (pick < 70) r.act = clf_pkg::ACT_NUMBER;
        else if (pick < 85) r.act = clf_pkg::ACT_CURSOR;
        else if (pick < 93) r.act = clf_pkg::ACT_CLEAR;
        else                r.act = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
        return r;
    endfunction

    task automatic send_request(input t_lcd_request r);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = {r.start, r.act};
        s_axis_tdata  = {r.col, r.row, r.num, r.bval};
        do @(posedge i_clk); while (!s_axis_tready);
        gap = tx_throttle ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_fields(input logic [2:0] act, input logic [7:0] bval,
                               input logic [31:0] num, input logic [7:0] row,
                               input logic [7:0] col, input logic start);
        send_request({act, start, bval, num, row, col});
    endtask

    task automatic send_string(input int len, input bit fresh);
        t_lcd_request r;
        for (int i = 0; i < len; i++) begin
            r = rand_request();
            r.act   = clf_pkg::ACT_STR_CHAR;
            r.start = (i == 0) ? fresh : 1'b0;
            send_request(r);
        end
    endtask

    // strings as runs with random content, mixed with single requests
    task automatic run_random(input int count);
        t_lcd_request r;
        int n;
        int len;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 1)) begin
                len = $urandom_range(1, 20);
                send_string(len, $urandom_range(0, 3) != 0);
                n += len;
            end else begin
                r = rand_request();
                send_request(r);
                if (r.act != ACT_SPARE6 && r.act != ACT_SPARE7) n++;
            end
        end
    endtask

    // drop valid, drain all expected words, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [clf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // raw writes and clear at the byte extremes
        send_fields(clf_pkg::ACT_COMMAND, 8'h00, $urandom(), rand_byte(), rand_byte(),
                    rand_bit());
        send_fields(clf_pkg::ACT_COMMAND, 8'hFF, $urandom(), rand_byte(), rand_byte(),
                    rand_bit());
        send_fields(clf_pkg::ACT_CHAR, 8'h00, $urandom(), rand_byte(), rand_byte(),
                    rand_bit());
        send_fields(clf_pkg::ACT_CHAR, 8'hFF, $urandom(), rand_byte(), rand_byte(),
                    rand_bit());
        send_fields(clf_pkg::ACT_CLEAR, rand_byte(), $urandom(), rand_byte(), rand_byte(),
                    rand_bit());
        // cursor: both row bases, last column, column out of range, other rows
        send_fields(clf_pkg::ACT_CURSOR, rand_byte(), $urandom(), 8'd0, 8'd0, rand_bit());
        send_fields(clf_pkg::ACT_CURSOR, rand_byte(), $urandom(), 8'd0, 8'd15, rand_bit());
        send_fields(clf_pkg::ACT_CURSOR, rand_byte(), $urandom(), 8'd1, 8'd15, rand_bit());
        send_fields(clf_pkg::ACT_CURSOR, rand_byte(), $urandom(), 8'd1, 8'd16, rand_bit());
        send_fields(clf_pkg::ACT_CURSOR, rand_byte(), $urandom(), 8'd2, 8'd5, rand_bit());
        send_fields(clf_pkg::ACT_CURSOR, rand_byte(), $urandom(), 8'hFF, 8'hFF, rand_bit());
        // numbers: zero, digit-count boundaries, ten digits, all ones
        send_fields(clf_pkg::ACT_NUMBER, rand_byte(), 32'd0, rand_byte(), rand_byte(),
                    rand_bit());
        send_fields(clf_pkg::ACT_NUMBER, rand_byte(), 32'd9, rand_byte(), rand_byte(),
                    rand_bit());
        send_fields(clf_pkg::ACT_NUMBER, rand_byte(), 32'd10, rand_byte(), rand_byte(),
                    rand_bit());
        send_fields(clf_pkg::ACT_NUMBER, rand_byte(), 32'd999_999_999, rand_byte(),
                    rand_byte(), rand_bit());
        send_fields(clf_pkg::ACT_NUMBER, rand_byte(), 32'd1_000_000_000, rand_byte(),
                    rand_byte(), rand_bit());
        send_fields(clf_pkg::ACT_NUMBER, rand_byte(), 32'hFFFF_FFFF, rand_byte(),
                    rand_byte(), rand_bit());
        // ignored actions
        send_fields(ACT_SPARE6, rand_byte(), $urandom(), rand_byte(), rand_byte(), rand_bit());
        send_fields(ACT_SPARE7, rand_byte(), $urandom(), rand_byte(), rand_byte(), rand_bit());
        send_string(4, 1'b1);
        settle();

        run_random(40);
        settle();

        // low extremes (high clear command), no idling on either side
        write_reg(clf_pkg::CFG_WRAP_INDEX, 8'd0);
        write_reg(clf_pkg::CFG_LINE2_COMMAND, 8'h00);
        write_reg(clf_pkg::CFG_CLEAR_COMMAND, 8'hFF);
        tx_throttle = 1'b0;
        rx_throttle = 1'b0;
        run_random(40);
        settle();
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;

        // high extremes (low clear command)
        write_reg(clf_pkg::CFG_WRAP_INDEX, 8'd255);
        write_reg(clf_pkg::CFG_LINE2_COMMAND, 8'hFF);
        write_reg(clf_pkg::CFG_CLEAR_COMMAND, 8'h00);
        send_string(30, 1'b1);
        run_random(30);
        settle();

        write_reg(clf_pkg::CFG_CLEAR_COMMAND, rand_byte());
        write_reg(clf_pkg::CFG_LINE2_COMMAND, rand_byte());
        write_reg(clf_pkg::CFG_WRAP_INDEX, 8'($urandom_range(0, 20)));
        run_random(50);
        settle();

        if (sb.pending_writes.size() != 0) begin
            $error("%0d expected writes never arrived", sb.pending_writes.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("[char_lcd_write_formatter_core] OK");
        else
            $display("[char_lcd_write_formatter_core] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/clf_pkg.sv
hdl/clf_bin2bcd.sv
hdl/char_lcd_write_formatter_core.sv
dv/tb_char_lcd_write_formatter_core.sv
